// ===== hw/rtl/pfa_pkg.sv =====
// pfa_pkg: shared types and register codes for the particle fade attribute pipeline
// no dependencies; imported by every pfa module and the top level
package pfa_pkg;

    localparam int unsigned LIFE_MIN     = 7;
    localparam int unsigned ONE_Q16      = 65536;
    localparam int unsigned DIV_STAGES   = 16;
    localparam int unsigned SQRT_STAGES  = 32;

    typedef enum logic [2:0] {
        REG_COLOR_START  = 3'd0,
        REG_COLOR_END    = 3'd1,
        REG_TRANSP_START = 3'd2,
        REG_TRANSP_END   = 3'd3,
        REG_SIZE_START   = 3'd4,
        REG_SIZE_END     = 3'd5,
        REG_BRIGHTNESS   = 3'd6
    } pfa_reg_t;

    typedef struct packed {
        logic [47:0] color_start;
        logic [47:0] color_end;
        logic [16:0] transp_start;
        logic [16:0] transp_end;
        logic [15:0] size_start;
        logic [15:0] size_end;
        logic [15:0] brightness;
    } pfa_cfg_t;

    typedef struct packed {
        logic [2:0][31:0] rel;
        logic [63:0]      sq;
    } pfa_geom_t;

    typedef struct packed {
        pfa_geom_t   geom;
        logic [23:0] age;
        logic [23:0] life;
    } pfa_front_t;

    typedef struct packed {
        pfa_geom_t   geom;
        logic [16:0] t;
    } pfa_fade_t;

    typedef struct packed {
        logic [2:0][31:0] rel;
        logic [14:0]      size;
        logic [2:0][15:0] color;
        logic [16:0]      opa;
        logic             vis;
    } pfa_attr_t;

    typedef struct packed {
        pfa_attr_t   attr;
        logic [63:0] sq;
    } pfa_shade_t;

    typedef struct packed {
        pfa_attr_t   attr;
        logic [31:0] radius;
    } pfa_result_t;

endpackage

// ===== hw/rtl/pfa_front.sv =====
// pfa_front: camera-relative position, squared magnitudes and their sum, lifetime floor
// three register stages; depends on pfa_pkg
module pfa_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0][31:0]    in_pos,
    input  logic [2:0][31:0]    in_cam,
    input  logic [23:0]         in_age,
    input  logic [23:0]         in_life,
    output logic                out_valid,
    input  logic                out_ready,
    output pfa_pkg::pfa_front_t out_data
);
    import pfa_pkg::*;

    logic             va_reg, vb_reg, vc_reg;
    logic             en_a, en_b, en_c;
    logic [2:0][31:0] rel_a_reg, mag_a_reg, rel_a_next, mag_a_next;
    logic [23:0]      age_a_reg, life_a_reg, life_a_next;
    logic [2:0][31:0] rel_b_reg;
    logic [2:0][63:0] sq_b_reg;
    logic [23:0]      age_b_reg, life_b_reg;
    pfa_front_t       c_reg, c_next;
    logic [2:0][32:0] diff;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {in_pos[k][31], in_pos[k]} - {in_cam[k][31], in_cam[k]};
            // saturate when the 33-bit difference leaves the 32-bit range
            if (diff[k][32] != diff[k][31]) begin
                rel_a_next[k] = diff[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                rel_a_next[k] = diff[k][31:0];
            end
            mag_a_next[k] = rel_a_next[k][31] ? (~rel_a_next[k] + 32'd1) : rel_a_next[k];
        end
        life_a_next = (in_life < 24'(LIFE_MIN)) ? 24'(LIFE_MIN) : in_life;
    end

    always_comb begin
        c_next.geom.rel = rel_b_reg;
        c_next.geom.sq  = sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];
        c_next.age      = age_b_reg;
        c_next.life     = life_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            rel_a_reg  <= rel_a_next;
            mag_a_reg  <= mag_a_next;
            age_a_reg  <= in_age;
            life_a_reg <= life_a_next;
        end
        if (en_b) begin
            // a full-scale magnitude of 2^31 squares to 2^62
            for (int k = 0; k < 3; k++) begin
                sq_b_reg[k] <= mag_a_reg[k] * mag_a_reg[k];
            end
            rel_b_reg  <= rel_a_reg;
            age_b_reg  <= age_a_reg;
            life_b_reg <= life_a_reg;
        end
        if (en_c) c_reg <= c_next;
    end

    assign out_valid = vc_reg;
    assign out_data  = c_reg;

endmodule

// ===== hw/rtl/pfa_div.sv =====
// pfa_div: restoring divider, one quotient bit per stage, forms the fade fraction t
// sixteen register stages; depends on pfa_pkg
module pfa_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfa_pkg::pfa_front_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfa_pkg::pfa_fade_t  out_data
);
    import pfa_pkg::*;

    logic        v_reg    [DIV_STAGES];
    logic        rdy      [DIV_STAGES+1];
    logic [23:0] rem_reg  [DIV_STAGES];
    logic [15:0] q_reg    [DIV_STAGES];
    logic [23:0] life_reg [DIV_STAGES];
    logic        sat_reg  [DIV_STAGES];
    pfa_geom_t   geom_reg [DIV_STAGES];

    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready        = rdy[0];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        logic        prev_valid;
        logic [23:0] prev_rem, prev_life, rem_next;
        logic [15:0] prev_q, q_next;
        logic        prev_sat;
        pfa_geom_t   prev_geom;
        logic [24:0] r2;
        logic        take;

        if (k == 0) begin : g_first
            // age at or past lifetime pins t at one, the remainder is unused
            assign prev_sat   = (in_data.age >= in_data.life);
            assign prev_rem   = prev_sat ? 24'd0 : in_data.age;
            assign prev_q     = 16'd0;
            assign prev_life  = in_data.life;
            assign prev_geom  = in_data.geom;
            assign prev_valid = in_valid;
        end else begin : g_rest
            assign prev_sat   = sat_reg[k-1];
            assign prev_rem   = rem_reg[k-1];
            assign prev_q     = q_reg[k-1];
            assign prev_life  = life_reg[k-1];
            assign prev_geom  = geom_reg[k-1];
            assign prev_valid = v_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            r2       = {prev_rem, 1'b0};
            take     = (r2 >= {1'b0, prev_life});
            rem_next = take ? 24'(r2 - {1'b0, prev_life}) : r2[23:0];
            q_next   = {prev_q[14:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                life_reg[k] <= prev_life;
                sat_reg[k]  <= prev_sat;
                geom_reg[k] <= prev_geom;
            end
        end
    end

    assign out_valid     = v_reg[DIV_STAGES-1];
    assign out_data.geom = geom_reg[DIV_STAGES-1];
    assign out_data.t    = sat_reg[DIV_STAGES-1] ? 17'(ONE_Q16)
                                                 : {1'b0, q_reg[DIV_STAGES-1]};

endmodule

// ===== hw/rtl/pfa_shade.sv =====
// pfa_shade: blends transparency, size and color by t, applies brightness and clamps
// two register stages; depends on pfa_pkg
module pfa_shade (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfa_pkg::pfa_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfa_pkg::pfa_fade_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfa_pkg::pfa_shade_t out_data
);
    import pfa_pkg::*;

    function automatic logic [16:0] blend(input logic [16:0] a, input logic [16:0] b,
                                          input logic [16:0] t);
        logic [35:0] acc;
        acc = 36'(a * (17'(ONE_Q16) - t)) + 36'(b * t) + 36'd32768;
        return acc[32:16];
    endfunction

    logic             vd_reg, ve_reg, en_d, en_e;
    logic [16:0]      tr_d_reg;
    logic [15:0]      sz_d_reg;
    logic [2:0][15:0] col_d_reg;
    pfa_geom_t        geom_d_reg;
    pfa_shade_t       e_reg, e_next;
    logic [16:0]      tr_b, sz_b;
    logic [2:0][16:0] col_b;
    logic [16:0]      opa;
    logic [32:0]      scaled;

    assign en_e     = !ve_reg || out_ready;
    assign en_d     = !vd_reg || en_e;
    assign in_ready = en_d;

    always_comb begin
        tr_b = blend(cfg.transp_start, cfg.transp_end, in_data.t);
        // signed sizes blend with an offset of half range
        sz_b = blend({1'b0, ~cfg.size_start[15], cfg.size_start[14:0]},
                     {1'b0, ~cfg.size_end[15], cfg.size_end[14:0]}, in_data.t);
        for (int k = 0; k < 3; k++) begin
            col_b[k] = blend({1'b0, cfg.color_start[16*k +: 16]},
                             {1'b0, cfg.color_end[16*k +: 16]}, in_data.t);
        end
    end

    always_comb begin
        opa = (tr_d_reg >= 17'(ONE_Q16)) ? 17'd0 : 17'(17'(ONE_Q16) - tr_d_reg);
        e_next = '0;
        scaled = '0;
        if (opa != 17'd0) begin
            e_next.attr.rel  = geom_d_reg.rel;
            e_next.sq        = geom_d_reg.sq;
            e_next.attr.size = sz_d_reg[15] ? sz_d_reg[14:0] : 15'd0;
            e_next.attr.opa  = opa;
            e_next.attr.vis  = 1'b1;
            for (int k = 0; k < 3; k++) begin
                scaled = 33'(col_d_reg[k] * cfg.brightness) + 33'd32768;
                e_next.attr.color[k] = (scaled[32:16] > 17'd65535) ? 16'hFFFF
                                                                   : scaled[31:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (en_d) vd_reg <= in_valid;
            if (en_e) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            tr_d_reg   <= tr_b;
            sz_d_reg   <= sz_b[15:0];
            for (int k = 0; k < 3; k++) col_d_reg[k] <= col_b[k][15:0];
            geom_d_reg <= in_data.geom;
        end
        if (en_e) e_reg <= e_next;
    end

    assign out_valid = ve_reg;
    assign out_data  = e_reg;

endmodule

// ===== hw/rtl/pfa_sqrt.sv =====
// pfa_sqrt: digit-by-digit integer square root, one result bit per stage
// thirty-two register stages, the last one is the output register; depends on pfa_pkg
module pfa_sqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfa_pkg::pfa_shade_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfa_pkg::pfa_result_t out_data
);
    import pfa_pkg::*;

    logic        v_reg    [SQRT_STAGES];
    logic        rdy      [SQRT_STAGES+1];
    logic [63:0] x_reg    [SQRT_STAGES];
    logic [63:0] res_reg  [SQRT_STAGES];
    pfa_attr_t   attr_reg [SQRT_STAGES];

    assign rdy[SQRT_STAGES] = out_ready;
    assign in_ready         = rdy[0];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic        prev_valid;
        logic [63:0] prev_x, prev_res, x_next, res_next;
        pfa_attr_t   prev_attr;
        logic [64:0] trial;

        if (k == 0) begin : g_first
            assign prev_x     = in_data.sq;
            assign prev_res   = 64'd0;
            assign prev_attr  = in_data.attr;
            assign prev_valid = in_valid;
        end else begin : g_rest
            assign prev_x     = x_reg[k-1];
            assign prev_res   = res_reg[k-1];
            assign prev_attr  = attr_reg[k-1];
            assign prev_valid = v_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            trial = {1'b0, prev_res} + {1'b0, BIT};
            if ({1'b0, prev_x} >= trial) begin
                x_next   = prev_x - trial[63:0];
                res_next = (prev_res >> 1) + BIT;
            end else begin
                x_next   = prev_x;
                res_next = prev_res >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                x_reg[k]    <= x_next;
                res_reg[k]  <= res_next;
                attr_reg[k] <= prev_attr;
            end
        end
    end

    // the sum of three squares stays below 2^64, so the root fits in 32 bits
    assign out_valid       = v_reg[SQRT_STAGES-1];
    assign out_data.attr   = attr_reg[SQRT_STAGES-1];
    assign out_data.radius = res_reg[SQRT_STAGES-1][31:0];

endmodule

// ===== hw/rtl/particle_fade_attributes.sv =====
// particle_fade_attributes: top level, configuration registers and the pipeline chain
// depends on pfa_pkg, pfa_front, pfa_div, pfa_shade, pfa_sqrt
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      position, camera origin, age, lifetime
//  m_        out        m_valid / m_ready      relative position, size, color, opacity,
//                                              distance, visible
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one particle per cycle sustained while m_ready stays high
// a particle passes the front end, the 16-stage divider, the shade and the 32-stage square root
// every stage holds its own valid bit; a stage advances when empty or when the next advances
// reset clears the valid bits and loads the register defaults
module particle_fade_attributes (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_cam_x,
    input  logic signed [31:0] s_cam_y,
    input  logic signed [31:0] s_cam_z,
    input  logic [23:0]        s_age,
    input  logic [23:0]        s_lifetime,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_rel_x,
    output logic signed [31:0] m_rel_y,
    output logic signed [31:0] m_rel_z,
    output logic [14:0]        m_draw_size,
    output logic [15:0]        m_red,
    output logic [15:0]        m_green,
    output logic [15:0]        m_blue,
    output logic [16:0]        m_opacity,
    output logic [31:0]        m_distance,
    output logic               m_visible
);
    import pfa_pkg::*;

    pfa_cfg_t    cfg_reg, cfg_next;
    pfa_front_t  front_data;
    pfa_fade_t   fade_data;
    pfa_shade_t  shade_data;
    pfa_result_t result;
    logic        front_valid, front_ready, fade_valid, fade_ready;
    logic        shade_valid, shade_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (pfa_reg_t'(cfg_index))
                REG_COLOR_START:  cfg_next.color_start  = cfg_data;
                REG_COLOR_END:    cfg_next.color_end    = cfg_data;
                REG_TRANSP_START: cfg_next.transp_start = cfg_data[16:0];
                REG_TRANSP_END:   cfg_next.transp_end   = cfg_data[16:0];
                REG_SIZE_START:   cfg_next.size_start   = cfg_data[15:0];
                REG_SIZE_END:     cfg_next.size_end     = cfg_data[15:0];
                REG_BRIGHTNESS:   cfg_next.brightness   = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_start  <= 48'hFFFF_FFFF_FFFF;
            cfg_reg.color_end    <= 48'hFFFF_FFFF_FFFF;
            cfg_reg.transp_start <= 17'd0;
            cfg_reg.transp_end   <= 17'd0;
            cfg_reg.size_start   <= 16'd256;
            cfg_reg.size_end     <= 16'd256;
            cfg_reg.brightness   <= 16'd256;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pos    ({s_pos_z, s_pos_y, s_pos_x}),
        .in_cam    ({s_cam_z, s_cam_y, s_cam_x}),
        .in_age    (s_age),
        .in_life   (s_lifetime),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    pfa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (fade_valid),
        .out_ready (fade_ready),
        .out_data  (fade_data)
    );

    pfa_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (fade_valid),
        .in_ready  (fade_ready),
        .in_data   (fade_data),
        .out_valid (shade_valid),
        .out_ready (shade_ready),
        .out_data  (shade_data)
    );

    pfa_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (shade_valid),
        .in_ready  (shade_ready),
        .in_data   (shade_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result)
    );

    assign m_rel_x     = result.attr.rel[0];
    assign m_rel_y     = result.attr.rel[1];
    assign m_rel_z     = result.attr.rel[2];
    assign m_draw_size = result.attr.size;
    assign m_red       = result.attr.color[0];
    assign m_green     = result.attr.color[1];
    assign m_blue      = result.attr.color[2];
    assign m_opacity   = result.attr.opa;
    assign m_distance  = result.radius;
    assign m_visible   = result.attr.vis;

    // a skipped particle carries an all-zero transaction
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_opacity == 17'd0 && m_distance == 32'd0
                                  && m_draw_size == 15'd0)
        else $error("invisible particle with nonzero fields");

    a_visible_opa: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |-> m_opacity != 17'd0 && m_opacity <= 17'(ONE_Q16))
        else $error("visible particle with opacity out of range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance) && $stable(m_opacity))
        else $error("stalled result changed inside the pipeline");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output stage is empty");

endmodule
